### design/nsv_pkg.sv
// ----------------------------------------------------------------------------
// nsv_pkg
// Shared types, codes and character helpers for the NMEA sentence validator.
// ----------------------------------------------------------------------------
package nsv_pkg;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_NO_DOLLAR = 3'd1;
    localparam logic [2:0] ERR_LINE_END  = 3'd2;
    localparam logic [2:0] ERR_TYPE_WORD = 3'd3;
    localparam logic [2:0] ERR_NO_COMMA  = 3'd4;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd5;
    localparam logic [2:0] ERR_SHORT     = 3'd6;

    localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
    localparam logic [1:0] TYPE_GPGLL   = 2'd1;
    localparam logic [1:0] TYPE_GPGGA   = 2'd2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;

    // Running sentence state as seen with the current byte applied
    typedef struct packed {
        logic [7:0] pos;        // position of the current byte
        logic [2:0] hdr_err;
        logic [1:0] type_bits;  // bit0 GPGLL, bit1 GPGGA
        logic [6:0] comma;
        logic [7:0] xor_sum;
        logic [7:0] b0;         // current byte
        logic [7:0] b1;         // one byte back
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;         // four bytes back
    } nsv_snap_t;

    function automatic logic [7:0] gll_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h50; // P
            3'd2:    c = 8'h47; // G
            3'd3:    c = 8'h4C; // L
            3'd4:    c = 8'h4C; // L
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] gga_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h50; // P
            3'd2:    c = 8'h47; // G
            3'd3:    c = 8'h47; // G
            3'd4:    c = 8'h41; // A
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {valid, digit}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Two-character hex value, read with leading space/sign like strtol
    function automatic logic [7:0] parse_pair(input logic [7:0] c1, input logic [7:0] c2);
        logic [4:0] d1;
        logic [4:0] d2;
        logic [7:0] v;
        d1 = hex_digit(c1);
        d2 = hex_digit(c2);
        v  = 8'd0;
        if (d1[4]) begin
            v = d2[4] ? {d1[3:0], d2[3:0]} : {4'd0, d1[3:0]};
        end else if (is_space(c1) || c1 == 8'h2B) begin
            v = d2[4] ? {4'd0, d2[3:0]} : 8'd0;
        end else if (c1 == 8'h2D) begin
            v = d2[4] ? 8'(8'd0 - {4'd0, d2[3:0]}) : 8'd0;
        end
        return v;
    endfunction

endpackage

### design/nsv_byte_tracker.sv
// ----------------------------------------------------------------------------
// nsv_byte_tracker
// Per-byte sentence state: header checks, type match, comma count, running
// XOR and the last five bytes. Clears after the final byte of a sentence.
// ----------------------------------------------------------------------------
module nsv_byte_tracker #(
    parameter int MAX_LEN = 82
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output nsv_pkg::nsv_snap_t snap
);

    logic [7:0] pos_reg;
    logic [7:0] xor_reg;
    logic       stopped_reg;
    logic [7:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic [2:0] hdr_err_reg;
    logic [1:0] type_bits_reg;
    logic [6:0] comma_reg;

    logic [7:0] pos_next;
    logic [7:0] xor_next;
    logic       stopped_next;
    logic [2:0] hdr_err_next;
    logic [1:0] type_bits_next;
    logic [6:0] comma_next;
    logic [2:0] type_idx;

    assign type_idx = 3'(pos_reg[2:0] - 3'd1);

    always_comb
    begin
        hdr_err_next   = hdr_err_reg;
        type_bits_next = type_bits_reg;
        comma_next     = comma_reg;
        xor_next       = xor_reg;
        stopped_next   = stopped_reg;

        if (pos_reg == 8'd0) begin
            if (data_byte != nsv_pkg::CH_DOLLAR && hdr_err_reg == nsv_pkg::ERR_OK)
                hdr_err_next = nsv_pkg::ERR_NO_DOLLAR;
        end else if (pos_reg <= 8'd5) begin
            if ((data_byte < nsv_pkg::CH_UPPER_A || data_byte > nsv_pkg::CH_UPPER_Z) &&
                hdr_err_reg == nsv_pkg::ERR_OK)
                hdr_err_next = nsv_pkg::ERR_TYPE_WORD;
            if (data_byte != nsv_pkg::gll_char(type_idx))
                type_bits_next[0] = 1'b0;
            if (data_byte != nsv_pkg::gga_char(type_idx))
                type_bits_next[1] = 1'b0;
        end else if (pos_reg == 8'd6) begin
            if (data_byte != nsv_pkg::CH_COMMA && hdr_err_reg == nsv_pkg::ERR_OK)
                hdr_err_next = nsv_pkg::ERR_NO_COMMA;
        end else if (data_byte == nsv_pkg::CH_COMMA && comma_reg != 7'd127) begin
            comma_next = 7'(comma_reg + 7'd1);
        end

        // stop accumulating at the first star or at the length limit
        if (pos_reg != 8'd0 && !stopped_reg) begin
            if (data_byte == nsv_pkg::CH_STAR || pos_reg >= 8'(MAX_LEN))
                stopped_next = 1'b1;
            else
                xor_next = xor_reg ^ data_byte;
        end

        pos_next = (pos_reg != 8'hFF) ? 8'(pos_reg + 8'd1) : pos_reg;
    end

    always_comb
    begin
        snap.pos       = pos_reg;
        snap.hdr_err   = hdr_err_next;
        snap.type_bits = type_bits_next;
        snap.comma     = comma_next;
        snap.xor_sum   = xor_next;
        snap.b0        = data_byte;
        snap.b1        = r0_reg;
        snap.b2        = r1_reg;
        snap.b3        = r2_reg;
        snap.b4        = r3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= 8'd0;
            xor_reg       <= 8'd0;
            stopped_reg   <= 1'b0;
            r0_reg        <= 8'd0;
            r1_reg        <= 8'd0;
            r2_reg        <= 8'd0;
            r3_reg        <= 8'd0;
            hdr_err_reg   <= nsv_pkg::ERR_OK;
            type_bits_reg <= 2'b11;
            comma_reg     <= 7'd0;
        end else if (take) begin
            if (last_byte) begin
                // sentence done: back to a clean slate
                pos_reg       <= 8'd0;
                xor_reg       <= 8'd0;
                stopped_reg   <= 1'b0;
                r0_reg        <= 8'd0;
                r1_reg        <= 8'd0;
                r2_reg        <= 8'd0;
                r3_reg        <= 8'd0;
                hdr_err_reg   <= nsv_pkg::ERR_OK;
                type_bits_reg <= 2'b11;
                comma_reg     <= 7'd0;
            end else begin
                pos_reg       <= pos_next;
                xor_reg       <= xor_next;
                stopped_reg   <= stopped_next;
                r0_reg        <= data_byte;
                r1_reg        <= r0_reg;
                r2_reg        <= r1_reg;
                r3_reg        <= r2_reg;
                hdr_err_reg   <= hdr_err_next;
                type_bits_reg <= type_bits_next;
                comma_reg     <= comma_next;
            end
        end
    end

endmodule

### design/nsv_result_eval.sv
// ----------------------------------------------------------------------------
// nsv_result_eval
// Final verdict on the closing byte and the result register toward the sink.
// ----------------------------------------------------------------------------
module nsv_result_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               check_en,
    input  nsv_pkg::nsv_snap_t snap,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [2:0]         error_code,
    output logic [1:0]         sentence_type,
    output logic [7:0]         field_count,
    output logic [7:0]         computed_checksum,
    output logic               has_checksum
);

    logic       out_valid_reg;
    logic [2:0] err_reg;
    logic [1:0] type_reg;
    logic [7:0] fields_reg;
    logic [7:0] csum_reg;
    logic       has_reg;

    logic [2:0] err_next;
    logic [1:0] type_next;
    logic       has_next;

    always_comb
    begin
        has_next = (snap.b4 == nsv_pkg::CH_STAR);

        if (snap.pos < 8'd5)
            type_next = nsv_pkg::TYPE_UNKNOWN;
        else if (snap.type_bits[0])
            type_next = nsv_pkg::TYPE_GPGLL;
        else if (snap.type_bits[1])
            type_next = nsv_pkg::TYPE_GPGGA;
        else
            type_next = nsv_pkg::TYPE_UNKNOWN;

        if (snap.pos < 8'd8)
            err_next = nsv_pkg::ERR_SHORT;
        else if (snap.hdr_err == nsv_pkg::ERR_NO_DOLLAR)
            err_next = nsv_pkg::ERR_NO_DOLLAR;
        else if (snap.b0 != nsv_pkg::CH_LF || snap.b1 != nsv_pkg::CH_CR)
            err_next = nsv_pkg::ERR_LINE_END;
        else if (snap.hdr_err != nsv_pkg::ERR_OK)
            err_next = snap.hdr_err;
        else if (check_en && has_next &&
                 nsv_pkg::parse_pair(snap.b3, snap.b2) != snap.xor_sum)
            err_next = nsv_pkg::ERR_CHECKSUM;
        else
            err_next = nsv_pkg::ERR_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            err_reg    <= err_next;
            type_reg   <= type_next;
            fields_reg <= 8'({1'b0, snap.comma} + 8'd1);
            csum_reg   <= snap.xor_sum;
            has_reg    <= has_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign error_code        = err_reg;
    assign sentence_type     = type_reg;
    assign field_count       = fields_reg;
    assign computed_checksum = csum_reg;
    assign has_checksum      = has_reg;

endmodule

### design/nmea_sentence_validator_unit.sv
// Result: registered; it shows in the cycle after the final byte of a sentence is accepted.
// Throughput: one byte per cycle unless a closing byte waits on an untaken result;
// the result register reloads as the old result is taken: sentences run back to back.
// Reset: rst_n clears sentence state and the result valid; the checksum
// check enable comes up set.
// ----------------------------------------------------------------------------
// nmea_sentence_validator_unit
// NMEA 0183 sentence checker: framing, type word, field count and checksum.
// ----------------------------------------------------------------------------
module nmea_sentence_validator_unit #(
    parameter int MAX_LEN = 82
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] error_code,
    output logic [1:0] sentence_type,
    output logic [7:0] field_count,
    output logic [7:0] computed_checksum,
    output logic       has_checksum
);

    logic               check_en_reg;
    logic               take;
    logic               load;
    nsv_pkg::nsv_snap_t snap;

    // only a closing byte needs a free result slot
    assign in_ready = !last_byte || !out_valid || out_ready;
    assign take     = in_valid && in_ready;
    assign load     = take && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            check_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            check_en_reg <= cfg_wr_data;
        end
    end

    nsv_byte_tracker #(
        .MAX_LEN (MAX_LEN)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .snap      (snap)
    );

    nsv_result_eval u_eval (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (load),
        .check_en          (check_en_reg),
        .snap              (snap),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .error_code        (error_code),
        .sentence_type     (sentence_type),
        .field_count       (field_count),
        .computed_checksum (computed_checksum),
        .has_checksum      (has_checksum)
    );

    a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("closing byte accepted but no result presented");

    a_csum_err_needs_star: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code == nsv_pkg::ERR_CHECKSUM) |-> has_checksum)
        else $error("checksum mismatch reported without a star mark");

    a_field_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (field_count != 8'd0 && field_count <= 8'd128))
        else $error("field count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !load)
        else $error("result overwritten before it was taken");

endmodule

### sim/nmea_sentence_validator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_validator_unit_tb
// Streams NMEA sentences byte by byte into the validator and checks each
// verdict against a cycle-free model of the framing, type-word, field-count
// and checksum rules, with random idling on both sides.
// ----------------------------------------------------------------------------
module nmea_sentence_validator_unit_tb;

    localparam int          MAX_LEN     = 82;
    localparam int unsigned CYCLE_LIMIT = 600000;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    // How the checksum pair after the star is written
    localparam int SUM_NONE  = 0;
    localparam int SUM_UPPER = 1;
    localparam int SUM_LOWER = 2;
    localparam int SUM_WRONG = 3;
    localparam int SUM_ODD   = 4;

    typedef struct packed {
        logic [2:0] err;
        logic [1:0] stype;
        logic [7:0] fields;
        logic [7:0] sum;
        logic       has;
    } verdict_t;

    class sentence_scoreboard;
        bit          check_on;
        int unsigned byte_idx;
        logic [7:0]  sum_acc;
        bit          sum_frozen;
        logic [7:0]  tail [5];
        logic [2:0]  hdr_fault;
        logic [1:0]  word_hits;
        int unsigned comma_seen;
        verdict_t    expected_verdicts [$];
        int unsigned mismatches;

        function new();
            check_on   = 1'b1;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            byte_idx   = 0;
            sum_acc    = 8'd0;
            sum_frozen = 1'b0;
            foreach (tail[i]) tail[i] = 8'd0;
            hdr_fault  = nsv_pkg::ERR_OK;
            word_hits  = 2'b11;
            comma_seen = 0;
        endfunction

        function int nibble_of(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
            if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
            if (c >= nsv_pkg::CH_UPPER_A && c <= CH_UPPER_F)
                return int'(c - nsv_pkg::CH_UPPER_A) + 10;
            return -1;
        endfunction

        // Two characters read the way strtol would read them in base 16
        function logic [7:0] read_pair(logic [7:0] c1, logic [7:0] c2);
            int hi;
            int lo;
            int v;
            hi = nibble_of(c1);
            lo = nibble_of(c2);
            if (hi >= 0) v = (lo >= 0) ? hi * 16 + lo : hi;
            else if (c1 == CH_SPACE || (c1 >= CH_TAB && c1 <= nsv_pkg::CH_CR) ||
                     c1 == CH_PLUS)
                v = (lo >= 0) ? lo : 0;
            else if (c1 == CH_MINUS) v = (lo >= 0) ? -lo : 0;
            else v = 0;
            return 8'(v);
        endfunction

        function void take_byte(logic [7:0] b, bit lst);
            int unsigned p;
            verdict_t    v;
            p = byte_idx;
            if (p == 0) begin
                if (b != nsv_pkg::CH_DOLLAR && hdr_fault == nsv_pkg::ERR_OK)
                    hdr_fault = nsv_pkg::ERR_NO_DOLLAR;
            end else if (p <= 5) begin
                if ((b < nsv_pkg::CH_UPPER_A || b > nsv_pkg::CH_UPPER_Z) &&
                    hdr_fault == nsv_pkg::ERR_OK)
                    hdr_fault = nsv_pkg::ERR_TYPE_WORD;
                if (b != gll_word(p - 1)) word_hits[0] = 1'b0;
                if (b != gga_word(p - 1)) word_hits[1] = 1'b0;
            end else if (p == 6) begin
                if (b != nsv_pkg::CH_COMMA && hdr_fault == nsv_pkg::ERR_OK)
                    hdr_fault = nsv_pkg::ERR_NO_COMMA;
            end else if (b == nsv_pkg::CH_COMMA && comma_seen < 127) begin
                comma_seen++;
            end

            // Freeze the sum at the first star or at the length limit
            if (p >= 1 && !sum_frozen) begin
                if (b == nsv_pkg::CH_STAR || p >= MAX_LEN) sum_frozen = 1'b1;
                else sum_acc ^= b;
            end

            for (int i = 4; i > 0; i--) tail[i] = tail[i - 1];
            tail[0] = b;
            if (byte_idx < 255) byte_idx++;

            if (!lst) return;

            v.has = (tail[4] == nsv_pkg::CH_STAR);
            if (p < 5) v.stype = nsv_pkg::TYPE_UNKNOWN;
            else if (word_hits[0]) v.stype = nsv_pkg::TYPE_GPGLL;
            else if (word_hits[1]) v.stype = nsv_pkg::TYPE_GPGGA;
            else v.stype = nsv_pkg::TYPE_UNKNOWN;

            if (p < 8) v.err = nsv_pkg::ERR_SHORT;
            else if (hdr_fault == nsv_pkg::ERR_NO_DOLLAR) v.err = nsv_pkg::ERR_NO_DOLLAR;
            else if (tail[0] != nsv_pkg::CH_LF || tail[1] != nsv_pkg::CH_CR)
                v.err = nsv_pkg::ERR_LINE_END;
            else if (hdr_fault != nsv_pkg::ERR_OK) v.err = hdr_fault;
            else if (check_on && v.has && read_pair(tail[3], tail[2]) != sum_acc)
                v.err = nsv_pkg::ERR_CHECKSUM;
            else v.err = nsv_pkg::ERR_OK;

            v.fields = 8'(comma_seen + 1);
            v.sum    = sum_acc;
            expected_verdicts.push_back(v);
            restart();
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: unexpected result err=%0d type=%0d fields=%0d",
                              " sum=%02h has=%0d"},
                             $realtime, got.err, got.stype, got.fields, got.sum, got.has);
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.err !== want.err || got.stype !== want.stype ||
                got.fields !== want.fields || got.sum !== want.sum ||
                got.has !== want.has) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch exp err=%0d type=%0d fields=%0d sum=%02h has=%0d",
                              " | got err=%0d type=%0d fields=%0d sum=%02h has=%0d"},
                             $realtime, want.err, want.stype, want.fields, want.sum, want.has,
                             got.err, got.stype, got.fields, got.sum, got.has);
            end
        endfunction

        function int unsigned pending();
            return expected_verdicts.size();
        endfunction

        function logic [7:0] gll_word(int unsigned k);
            logic [39:0] w;
            w = "GPGLL";
            return w[8 * (4 - k) +: 8];
        endfunction

        function logic [7:0] gga_word(int unsigned k);
            logic [39:0] w;
            w = "GPGGA";
            return w[8 * (4 - k) +: 8];
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] error_code;
    logic [1:0] sentence_type;
    logic [7:0] field_count;
    logic [7:0] computed_checksum;
    logic       has_checksum;

    sentence_scoreboard sb;
    logic [7:0]  line_buf [$];
    int unsigned bytes_sent  = 0;
    int unsigned cycle_count = 0;
    int          ready_hold  = 0;
    bit          sender_idle = 1'b1;
    bit          sink_idle   = 1'b1;

    nmea_sentence_validator_unit #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .error_code       (error_code),
        .sentence_type    (sentence_type),
        .field_count      (field_count),
        .computed_checksum(computed_checksum),
        .has_checksum     (has_checksum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("nmea_sentence_validator_unit test failed");
            $finish;
        end
    end

    function automatic int draw_gap(bit on);
        return on ? int'($urandom_range(0, 19)) : 0;
    endfunction

    function automatic logic [7:0] rand_upper();
        return 8'($urandom_range(65, 90));
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib, bit lower);
        if (nib < 10) return CH_ZERO + 8'(nib);
        return (lower ? CH_LOWER_A : nsv_pkg::CH_UPPER_A) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] odd_char();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_PLUS;
            2:       return CH_MINUS;
            3:       return 8'($urandom_range(9, 13));
            4:       return hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1) == 1);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void start_line(logic [39:0] word);
        line_buf = {};
        line_buf.push_back(nsv_pkg::CH_DOLLAR);
        for (int k = 4; k >= 0; k--) line_buf.push_back(word[8 * k +: 8]);
        line_buf.push_back(nsv_pkg::CH_COMMA);
    endfunction

    function automatic void put_crlf();
        line_buf.push_back(nsv_pkg::CH_CR);
        line_buf.push_back(nsv_pkg::CH_LF);
    endfunction

    // Append a star and a pair; the good forms carry the true sentence sum
    function automatic void put_sum(int how);
        logic [7:0] s;
        int         i;
        s = 8'd0;
        i = 1;
        while (i < line_buf.size() && i < MAX_LEN && line_buf[i] != nsv_pkg::CH_STAR)
        begin
            s ^= line_buf[i];
            i++;
        end
        if (how == SUM_WRONG) s ^= 8'($urandom_range(1, 255));
        line_buf.push_back(nsv_pkg::CH_STAR);
        if (how == SUM_ODD)
        begin
            line_buf.push_back(odd_char());
            line_buf.push_back(odd_char());
        end
        else
        begin
            line_buf.push_back(hex_char(s[7:4], how == SUM_LOWER));
            line_buf.push_back(hex_char(s[3:0], how == SUM_LOWER));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit lst);
        int gap;
        gap = draw_gap(sender_idle);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do @(posedge clk); while (!(in_valid && in_ready));
        sb.take_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    // Hold the input until every pending verdict has been collected
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic set_checking(input bit on);
        drain();
        repeat (3) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.check_on = on;
    endtask

    initial
    begin : result_sink
        int       gap_left;
        verdict_t got;
        gap_left  = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                out_ready <= 1'b0;
                ready_hold--;
            end
            else if (gap_left > 0)
            begin
                out_ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.err    = error_code;
                got.stype  = sentence_type;
                got.fields = field_count;
                got.sum    = computed_checksum;
                got.has    = has_checksum;
                sb.check_verdict(got);
                gap_left = draw_gap(sink_idle);
            end
        end
    end

    initial
    begin : stimulus
        string       odd_pairs [7];
        logic [39:0] word;
        int          nf;
        int          k;
        int unsigned phase_end;
        bit          paused;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = 8'd0;
        last_byte   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Well-formed sentences of both known types and an unknown one, then a near miss with a wrong sum
        start_line("GPGLL"); put_text("4916.45,N,12311.12,W"); put_sum(SUM_UPPER);
        put_crlf(); send_line();
        start_line("GPGGA"); put_text("1,2,,3"); put_sum(SUM_LOWER); put_crlf(); send_line();
        start_line("GNRMC"); put_text("A,B"); put_crlf(); send_line();
        start_line("GPGLX"); put_text("0"); put_sum(SUM_WRONG); put_crlf(); send_line();

        // Header faults, alone and together
        line_buf = {}; put_text("#GPGLL,1"); put_crlf(); send_line();
        start_line("GPgLL"); put_text("1"); put_crlf(); send_line();
        line_buf = {}; put_text("$GPGLL;1,2"); put_crlf(); send_line();
        line_buf = {}; put_text("#GPG1L;"); put_crlf(); send_line();
        line_buf = {}; put_text("$GP1LL;"); put_crlf(); send_line();

        // Line end: doubled LF, then swapped CR and LF
        start_line("GPGGA"); put_text("x");
        line_buf.push_back(nsv_pkg::CH_LF); line_buf.push_back(nsv_pkg::CH_LF); send_line();
        start_line("GPGGA"); put_text("x");
        line_buf.push_back(nsv_pkg::CH_LF); line_buf.push_back(nsv_pkg::CH_CR); send_line();

        // Shortest complete sentence, then too short with and without a type word
        start_line("GPGLL"); put_crlf(); send_line();
        line_buf = {}; put_text("$GPGLL"); put_crlf(); send_line();
        line_buf = {}; put_text("$GPGGA"); send_line();
        line_buf = {}; put_text("$GPGG"); send_line();
        line_buf = {}; line_buf.push_back(nsv_pkg::CH_DOLLAR); send_line();

        // Checksum pairs read with a sign, blank or stray character
        odd_pairs = '{" 5", "+5", "-5", "-x", "5x", "zz", "\tA"};
        foreach (odd_pairs[i])
        begin
            start_line("GPGLL"); put_text("1");
            line_buf.push_back(nsv_pkg::CH_STAR); put_text(odd_pairs[i]); put_crlf();
            send_line();
        end

        // Extreme byte values inside a field
        start_line("GPGGA");
        line_buf.push_back(8'h00); line_buf.push_back(8'hFF);
        line_buf.push_back(nsv_pkg::CH_COMMA);
        put_sum(SUM_UPPER); put_crlf(); send_line();

        // Past the sum limit, and past the position and comma limits
        start_line("GPGLL"); repeat (40) put_text("9,"); put_sum(SUM_UPPER);
        put_crlf(); send_line();
        start_line("GPGGA"); repeat (150) put_text("7,"); put_sum(SUM_LOWER);
        put_crlf(); send_line();

        // Same sort of faulty pairs with checking off
        set_checking(1'b0);
        start_line("GPGGA"); put_text("5,6"); put_sum(SUM_WRONG); put_crlf(); send_line();
        start_line("GPGLL"); put_text("5"); put_sum(SUM_ODD); put_crlf(); send_line();

        for (int ph = 0; ph < 3; ph++)
        begin
            set_checking(ph != 1);
            sender_idle = (ph != 1);
            sink_idle   = (ph != 1);
            // Stall the result side while bytes keep coming
            if (ph == 1) ready_hold = 300;
            phase_end = bytes_sent + 340;
            paused    = 1'b0;
            while (bytes_sent < phase_end)
            begin
                if (ph == 0 && !paused && bytes_sent + 170 > phase_end)
                begin
                    drain();
                    paused = 1'b1;
                end

                case ($urandom_range(0, 3))
                    0: word = "GPGLL";
                    1: word = "GPGGA";
                    2: word = {rand_upper(), rand_upper(), rand_upper(), rand_upper(),
                               rand_upper()};
                    default:
                    begin
                        word = $urandom_range(0, 1) ? "GPGLL" : "GPGGA";
                        k = $urandom_range(0, 4);
                        word[8 * k +: 8] = rand_upper();
                    end
                endcase
                start_line(word);

                nf = ($urandom_range(0, 32) == 0) ? $urandom_range(20, 70)
                                                  : $urandom_range(0, 6);
                for (int f = 0; f < nf; f++)
                begin
                    if (f > 0) line_buf.push_back(nsv_pkg::CH_COMMA);
                    repeat ($urandom_range(0, 5))
                        line_buf.push_back(8'($urandom_range(32, 126)));
                end

                k = $urandom_range(0, 99);
                if (k < 40) put_sum(SUM_UPPER);
                else if (k < 60) put_sum(SUM_LOWER);
                else if (k < 75) put_sum(SUM_WRONG);
                else if (k < 85) put_sum(SUM_ODD);
                put_crlf();

                // Break about a third of the sentences
                if ($urandom_range(0, 9) < 3)
                begin
                    case ($urandom_range(0, 6))
                        0: line_buf[0] = 8'($urandom_range(0, 255));
                        1: line_buf[$urandom_range(1, 5)] = 8'($urandom_range(0, 255));
                        2: line_buf[6] = 8'($urandom_range(0, 255));
                        3: line_buf[line_buf.size() - $urandom_range(1, 2)] =
                               8'($urandom_range(0, 255));
                        4:
                        begin
                            k = $urandom_range(1, 9);
                            while (line_buf.size() > k) void'(line_buf.pop_back());
                        end
                        5:
                        begin
                            line_buf = {};
                            repeat ($urandom_range(1, 24))
                                line_buf.push_back(8'($urandom_range(0, 255)));
                        end
                        default:
                            line_buf[$urandom_range(1, line_buf.size() - 1)] =
                                $urandom_range(0, 1) ? nsv_pkg::CH_STAR
                                                     : 8'($urandom_range(0, 255));
                    endcase
                end
                send_line();

                if (ready_hold == 0)
                begin
                    if ($urandom_range(0, 5) == 0) sender_idle = !sender_idle;
                    if ($urandom_range(0, 5) == 0) sink_idle = !sink_idle;
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("nmea_sentence_validator_unit test passed");
        else
            $display("nmea_sentence_validator_unit test failed");
        $finish;
    end

endmodule
